// ----- src/ppte_pkg.sv -----
// Package for the piecewise polynomial trajectory evaluator.
// Holds payload and command types, codes and the fixed-point helper functions.
// No dependencies.
package ppte_pkg;

    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_COEF = 2'd1,
        OP_DUR  = 2'd2,
        OP_NONE = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        CFG_TICK_STEP     = 2'd0,
        CFG_LEAD_IN_TIME  = 2'd1,
        CFG_HOVER_HEIGHT  = 2'd2,
        CFG_SEGMENTS_USED = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        PH_LEAD  = 2'd0,
        PH_TRAJ  = 2'd1,
        PH_HOVER = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_COEF,
        CMD_DUR
    } t_cmd_kind;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SRD,
        ST_SACC,
        ST_DEC,
        ST_RD,
        ST_MUL1,
        ST_MUL2,
        ST_ADD,
        ST_FIN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [1:0]         axis;
        logic [3:0]         segment;
        logic [3:0]         coef_index;
        logic signed [63:0] load_value;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] pos_x;
        logic signed [47:0] pos_y;
        logic signed [47:0] pos_z;
        logic signed [47:0] vel_x;
        logic signed [47:0] vel_y;
        logic signed [47:0] vel_z;
        logic signed [47:0] acc_x;
        logic signed [47:0] acc_y;
        logic signed [47:0] acc_z;
        logic [1:0]         phase;
        logic [3:0]         active_segment;
    } t_out_item;

    typedef struct packed {
        t_cmd_kind          kind;
        logic [1:0]         axis;
        logic [3:0]         segment;
        logic [3:0]         coef_index;
        logic signed [63:0] value;
    } t_cmd;

    typedef struct packed {
        logic [24:0]        tick_step;
        logic [35:0]        lead_in_time;
        logic signed [47:0] hover_height;
        logic [4:0]         segments_used;
    } t_cfg;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic logic signed [63:0] from_sign_mag(input logic neg, input logic [63:0] m);
        if (neg) begin
            return m[63] ? S64_MIN : signed'(64'd0 - m);
        end
        return m[63] ? S64_MAX : signed'(m);
    endfunction

    function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                     input logic signed [63:0] b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s[64] != s[63]) begin
            return s[64] ? S64_MIN : S64_MAX;
        end
        return s[63:0];
    endfunction

    function automatic logic [7:0] weight(input logic [3:0] k, input logic [1:0] order);
        case (order)
            2'd0:    return 8'd1;
            2'd1:    return {4'd0, k};
            default: return (k == 4'd0) ? 8'd0 : 8'(k) * 8'(k - 4'd1);
        endcase
    endfunction

    function automatic logic signed [63:0] mul_small(input logic signed [63:0] c,
                                                     input logic [7:0] k);
        logic [71:0] p;
        logic [63:0] m;
        p = {8'd0, mag_of(c)} * {64'd0, k};
        m = (|p[71:64]) ? 64'hFFFF_FFFF_FFFF_FFFF : p[63:0];
        return from_sign_mag(c[63], m);
    endfunction

    function automatic logic signed [47:0] to_q16_32(input logic signed [63:0] acc);
        logic [64:0] s;
        logic [56:0] q;
        logic [56:0] r;
        s = {1'b0, mag_of(acc)} + 65'd128;
        q = s[64:8];
        if (acc[63]) begin
            if (q > 57'h0_8000_0000_0000) q = 57'h0_8000_0000_0000;
            r = 57'd0 - q;
            return signed'(r[47:0]);
        end
        if (q > 57'h0_7FFF_FFFF_FFFF) q = 57'h0_7FFF_FFFF_FFFF;
        return signed'(q[47:0]);
    endfunction

    function automatic logic signed [47:0] sat48_add(input logic signed [47:0] a,
                                                     input logic signed [47:0] b);
        logic signed [48:0] s;
        s = 49'(a) + 49'(b);
        if (s[48] != s[47]) begin
            return s[48] ? 48'sh8000_0000_0000 : 48'sh7FFF_FFFF_FFFF;
        end
        return s[47:0];
    endfunction

endpackage

// ----- src/ppte_fifo.sv -----
// Command queue between the front and back parts of the evaluator.
// Depends on ppte_pkg for the command type and queue depth.
module ppte_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  ppte_pkg::t_cmd  i_data,
    output logic            o_full,
    output logic            o_valid,
    input  logic            i_pop,
    output ppte_pkg::t_cmd  o_data
);

    localparam int AW = (ppte_pkg::QDEPTH > 1) ? $clog2(ppte_pkg::QDEPTH) : 1;
    localparam int CW = $clog2(ppte_pkg::QDEPTH + 1);

    ppte_pkg::t_cmd r_mem [ppte_pkg::QDEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [CW-1:0]  r_cnt;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_cnt == CW'(ppte_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == AW'(ppte_pkg::QDEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == AW'(ppte_pkg::QDEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

endmodule

// ----- src/ppte_front.sv -----
// Front part: accepts input words, checks and decodes them into commands.
// Depends on ppte_pkg and ppte_fifo.
module ppte_front #(
    parameter int MAX_SEGMENTS = 16,
    parameter int COEFF_COUNT  = 10
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ppte_pkg::t_in_item i_in_data,
    output logic               o_cmd_valid,
    input  logic               i_cmd_pop,
    output ppte_pkg::t_cmd     o_cmd
);

    logic           full;
    logic           keep;
    logic           seg_ok;
    ppte_pkg::t_cmd cmd;

    assign o_in_ready = !full;
    assign seg_ok     = (32'(i_in_data.segment) < MAX_SEGMENTS);

    always_comb begin
        cmd.axis       = i_in_data.axis;
        cmd.segment    = i_in_data.segment;
        cmd.coef_index = i_in_data.coef_index;
        cmd.value      = i_in_data.load_value;
        cmd.kind       = ppte_pkg::CMD_TICK;
        keep           = 1'b0;
        case (i_in_data.opcode)
            ppte_pkg::OP_TICK: begin
                keep = 1'b1;
            end
            ppte_pkg::OP_COEF: begin
                cmd.kind = ppte_pkg::CMD_COEF;
                keep     = seg_ok && (i_in_data.axis != 2'd3)
                           && (32'(i_in_data.coef_index) < COEFF_COUNT);
            end
            ppte_pkg::OP_DUR: begin
                cmd.kind = ppte_pkg::CMD_DUR;
                keep     = seg_ok;
                if (i_in_data.load_value[63]) begin
                    cmd.value = '0;
                end else if (|i_in_data.load_value[62:36]) begin
                    cmd.value = 64'sh0000_000F_FFFF_FFFF;
                end
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    ppte_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_in_valid && keep),
        .i_data  (cmd),
        .o_full  (full),
        .o_valid (o_cmd_valid),
        .i_pop   (i_cmd_pop),
        .o_data  (o_cmd)
    );

endmodule

// ----- src/ppte_back.sv -----
// Back part: coefficient and duration stores, segment search and the shared
// Horner multiply unit; holds the time state and the output register.
// Depends on ppte_pkg.
module ppte_back #(
    parameter int MAX_SEGMENTS = 16,
    parameter int COEFF_COUNT  = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  ppte_pkg::t_cfg      i_cfg,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    input  ppte_pkg::t_cmd      i_cmd,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ppte_pkg::t_out_item o_out_data
);

    localparam int SW  = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int JW  = $clog2(MAX_SEGMENTS + 1);
    localparam int KW  = $clog2(COEFF_COUNT);
    localparam int CD  = 3 * MAX_SEGMENTS * COEFF_COUNT;
    localparam int CAW = $clog2(CD);
    localparam int CW  = 36 + JW;

    ppte_pkg::t_state   r_state;
    ppte_pkg::t_state   n_state;

    logic signed [63:0] mem_coef [CD];
    logic [35:0]        mem_dur [MAX_SEGMENTS];
    logic signed [63:0] r_coef;
    logic [35:0]        r_dur_q;

    logic [35:0]        r_elapsed;
    logic [35:0]        r_traj;
    logic [JW-1:0]      r_j;
    logic [CW-1:0]      r_cum;
    logic               r_found;
    logic [JW-1:0]      r_seg;
    logic [35:0]        r_local;
    logic [1:0]         r_o;
    logic [1:0]         r_a;
    logic [KW-1:0]      r_k;
    logic signed [63:0] r_acc;
    logic [67:0]        r_plo;
    logic [67:0]        r_phi;
    logic signed [63:0] r_wc;
    logic signed [63:0] r_mt;
    logic signed [47:0] r_res [9];
    logic signed [47:0] r_zoff;
    logic [1:0]         r_phase;
    logic [3:0]         r_active;
    logic               r_ovld;
    ppte_pkg::t_out_item r_out;

    logic [JW-1:0]      used;
    logic               we_coef;
    logic               we_dur;
    logic [CAW-1:0]     wa_coef;
    logic [CAW-1:0]     ra_coef;
    logic [CW-1:0]      cum_new;
    logic [CW:0]        limit;
    logic               in_lead;
    logic               in_traj;
    logic               do_eval;
    logic [36:0]        el_sum;
    logic [36:0]        tr_sum;
    logic [63:0]        acc_mag;
    logic [99:0]        prod;
    logic [99:0]        rnd;
    logic [63:0]        mt_q;
    logic [3:0]         res_idx;
    logic               last_step;
    logic               emit_go;

    assign used    = (32'(i_cfg.segments_used) > MAX_SEGMENTS) ? JW'(MAX_SEGMENTS)
                                                               : JW'(i_cfg.segments_used);
    assign we_coef = (r_state == ppte_pkg::ST_IDLE) && i_cmd_valid
                     && (i_cmd.kind == ppte_pkg::CMD_COEF);
    assign we_dur  = (r_state == ppte_pkg::ST_IDLE) && i_cmd_valid
                     && (i_cmd.kind == ppte_pkg::CMD_DUR);
    assign wa_coef = CAW'((32'(i_cmd.axis) * MAX_SEGMENTS + 32'(i_cmd.segment)) * COEFF_COUNT
                          + 32'(i_cmd.coef_index));
    assign ra_coef = CAW'((32'(r_a) * MAX_SEGMENTS + 32'(r_seg)) * COEFF_COUNT + 32'(r_k));

    assign cum_new = r_cum + CW'(r_dur_q);
    assign limit   = (CW + 1)'(i_cfg.lead_in_time) + (CW + 1)'(r_cum);
    assign in_lead = (r_elapsed < i_cfg.lead_in_time);
    assign in_traj = ((CW + 1)'(r_elapsed) < limit);
    assign do_eval = !in_lead && in_traj && r_found;
    assign el_sum  = {1'b0, r_elapsed} + 37'(i_cfg.tick_step);
    assign tr_sum  = {1'b0, r_traj} + 37'(i_cfg.tick_step);

    assign acc_mag = ppte_pkg::mag_of(r_acc);
    assign prod    = {r_phi, 32'd0} + {32'd0, r_plo};
    assign rnd     = prod + 100'h80_0000;
    assign mt_q    = (|rnd[99:88]) ? 64'hFFFF_FFFF_FFFF_FFFF : rnd[87:24];
    assign res_idx = 4'({2'd0, r_o} * 4'd3 + {2'd0, r_a});
    assign last_step = (32'(r_k) <= 32'(r_o));
    assign emit_go = !r_ovld || i_out_ready;

    assign o_out_valid = r_ovld;
    assign o_out_data  = r_out;

    always_comb begin
        n_state   = r_state;
        o_cmd_pop = 1'b0;
        case (r_state)
            ppte_pkg::ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.kind == ppte_pkg::CMD_TICK) begin
                        n_state = (used == '0) ? ppte_pkg::ST_DEC : ppte_pkg::ST_SRD;
                    end
                end
            end
            ppte_pkg::ST_SRD:  n_state = ppte_pkg::ST_SACC;
            ppte_pkg::ST_SACC: begin
                n_state = (r_j + 1'b1 == used) ? ppte_pkg::ST_DEC : ppte_pkg::ST_SRD;
            end
            ppte_pkg::ST_DEC:  n_state = do_eval ? ppte_pkg::ST_RD : ppte_pkg::ST_EMIT;
            ppte_pkg::ST_RD:   n_state = ppte_pkg::ST_MUL1;
            ppte_pkg::ST_MUL1: n_state = ppte_pkg::ST_MUL2;
            ppte_pkg::ST_MUL2: n_state = ppte_pkg::ST_ADD;
            ppte_pkg::ST_ADD:  n_state = last_step ? ppte_pkg::ST_FIN : ppte_pkg::ST_RD;
            ppte_pkg::ST_FIN: begin
                n_state = (r_o == 2'd2 && r_a == 2'd2) ? ppte_pkg::ST_EMIT : ppte_pkg::ST_RD;
            end
            ppte_pkg::ST_EMIT: n_state = emit_go ? ppte_pkg::ST_IDLE : ppte_pkg::ST_EMIT;
            default:           n_state = ppte_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ppte_pkg::ST_IDLE;
            r_elapsed <= '0;
            r_traj    <= '0;
            r_ovld    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ppte_pkg::ST_DEC) begin
                r_elapsed <= el_sum[36] ? 36'hF_FFFF_FFFF : el_sum[35:0];
                if (!in_lead && in_traj) begin
                    r_traj <= tr_sum[36] ? 36'hF_FFFF_FFFF : tr_sum[35:0];
                end
            end
            if (r_state == ppte_pkg::ST_EMIT && emit_go) begin
                r_ovld <= 1'b1;
            end else if (i_out_ready) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_coef) begin
            mem_coef[wa_coef] <= i_cmd.value;
        end
        r_coef <= mem_coef[ra_coef];
    end

    always_ff @(posedge i_clk) begin
        if (we_dur) begin
            mem_dur[SW'(i_cmd.segment)] <= i_cmd.value[35:0];
        end
        r_dur_q <= mem_dur[r_j[SW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            ppte_pkg::ST_IDLE: begin
                r_j     <= '0;
                r_cum   <= '0;
                r_found <= 1'b0;
                r_seg   <= '0;
            end
            ppte_pkg::ST_SACC: begin
                r_cum <= cum_new;
                r_j   <= r_j + 1'b1;
                if (!r_found && (CW'(r_traj) < cum_new)) begin
                    r_found <= 1'b1;
                    r_seg   <= r_j;
                    r_local <= r_traj - r_cum[35:0];
                end
            end
            ppte_pkg::ST_DEC: begin
                for (int i = 0; i < 9; i++) begin
                    r_res[i] <= '0;
                end
                r_active <= do_eval ? 4'(r_seg) : 4'd0;
                r_o      <= 2'd0;
                r_a      <= 2'd0;
                r_k      <= KW'(COEFF_COUNT - 1);
                r_acc    <= '0;
                if (in_lead) begin
                    r_phase <= ppte_pkg::PH_LEAD;
                    r_zoff  <= i_cfg.hover_height;
                end else if (in_traj) begin
                    r_phase <= ppte_pkg::PH_TRAJ;
                    r_zoff  <= r_found ? i_cfg.hover_height : 48'sd0;
                end else begin
                    r_phase <= ppte_pkg::PH_HOVER;
                    r_zoff  <= i_cfg.hover_height;
                end
            end
            ppte_pkg::ST_MUL1: begin
                r_plo <= 68'(acc_mag[31:0]) * 68'(r_local);
                r_phi <= 68'(acc_mag[63:32]) * 68'(r_local);
                r_wc  <= ppte_pkg::mul_small(r_coef, ppte_pkg::weight(4'(r_k), r_o));
            end
            ppte_pkg::ST_MUL2: begin
                r_mt <= ppte_pkg::from_sign_mag(r_acc[63], mt_q);
            end
            ppte_pkg::ST_ADD: begin
                r_acc <= ppte_pkg::sat_add64(r_mt, r_wc);
                r_k   <= r_k - 1'b1;
            end
            ppte_pkg::ST_FIN: begin
                r_res[res_idx] <= ppte_pkg::to_q16_32(r_acc);
                r_acc <= '0;
                r_k   <= KW'(COEFF_COUNT - 1);
                if (r_a == 2'd2) begin
                    r_a <= 2'd0;
                    r_o <= r_o + 2'd1;
                end else begin
                    r_a <= r_a + 2'd1;
                end
            end
            ppte_pkg::ST_EMIT: begin
                if (emit_go) begin
                    r_out.pos_x          <= r_res[0];
                    r_out.pos_y          <= r_res[1];
                    r_out.pos_z          <= ppte_pkg::sat48_add(r_res[2], r_zoff);
                    r_out.vel_x          <= r_res[3];
                    r_out.vel_y          <= r_res[4];
                    r_out.vel_z          <= r_res[5];
                    r_out.acc_x          <= r_res[6];
                    r_out.acc_y          <= r_res[7];
                    r_out.acc_z          <= r_res[8];
                    r_out.phase          <= r_phase;
                    r_out.active_segment <= r_active;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

// ----- src/piecewise_poly_trajectory_eval_core.sv -----
// Top level of the piecewise polynomial trajectory evaluator.
// Holds the configuration registers; joins ppte_front and ppte_back (ppte_pkg).
//
// Load words (coefficient or duration) are written to their store while the back
// part is idle and give no result. A tick gives one result: a search through the
// duration store, with a read and an accumulate step for each segment in use,
// then, when the tick falls in the trajectory phase and a segment is found, nine
// Horner evaluations on one shared multiply unit, each with a read, two multiply
// steps and an add per coefficient plus one finish step; other ticks skip them.
// A two-entry command queue and the output register let input and output stall
// on their own. Stores have no reset; a tick must not read unwritten entries.
module piecewise_poly_trajectory_eval_core #(
    parameter int MAX_SEGMENTS = 16,
    parameter int COEFF_COUNT  = 10
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  ppte_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output ppte_pkg::t_out_item o_out_data,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [47:0]         i_cfg_data
);

    ppte_pkg::t_cfg r_cfg;
    ppte_pkg::t_cmd cmd;
    logic           cmd_valid;
    logic           cmd_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_step     <= 25'd83886;
            r_cfg.lead_in_time  <= 36'd50331648;
            r_cfg.hover_height  <= 48'sd4294967296;
            r_cfg.segments_used <= 5'd11;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ppte_pkg::CFG_TICK_STEP:     r_cfg.tick_step     <= i_cfg_data[24:0];
                ppte_pkg::CFG_LEAD_IN_TIME:  r_cfg.lead_in_time  <= i_cfg_data[35:0];
                ppte_pkg::CFG_HOVER_HEIGHT:  r_cfg.hover_height  <= signed'(i_cfg_data);
                ppte_pkg::CFG_SEGMENTS_USED: r_cfg.segments_used <= i_cfg_data[4:0];
                default: begin
                end
            endcase
        end
    end

    ppte_front #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COEFF_COUNT  (COEFF_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop),
        .o_cmd       (cmd)
    );

    ppte_back #(
        .MAX_SEGMENTS (MAX_SEGMENTS),
        .COEFF_COUNT  (COEFF_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .i_cmd       (cmd),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule
